/* rtl/core/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg : shared definitions for the sensor pair line parser
// Scan phase codes, character codes, character classes and the result struct.
// ----------------------------------------------------------------------------
package spl_pkg;

   localparam int unsigned PHASE_W = 3;

   // scan phase codes
   localparam logic [PHASE_W-1:0] PH_SEARCH = 3'd0;
   localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_GAP1   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_GAP2   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_SECOND = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int unsigned OUT_W = 32;

   typedef struct packed {
      logic             emit;
      logic [OUT_W-1:0] controller_id;
      logic [OUT_W-1:0] bit_mask;
      logic             value_saturated;
   } scan_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // space, tab, LF, VT, FF, CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

/* rtl/core/spl_scan.sv */
// ----------------------------------------------------------------------------
// spl_scan : line scanner state and per-beat update
// Tracks CR LF line ends, the pair match phase and the two decimal values.
// ----------------------------------------------------------------------------
module spl_scan #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output spl_pkg::scan_result_type scan_res
);

   logic [spl_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [VALUE_BITS-1:0]       first_ff, first_in;
   logic [VALUE_BITS-1:0]       second_ff, second_in;
   logic                        cr_pending_ff, cr_pending_in;
   logic                        clamp_ff, clamp_in;

   logic [spl_pkg::PHASE_W-1:0] ph_mid;
   logic                        dg, ws, cm, line_end;
   logic [3:0]                  digit;
   logic [VALUE_BITS-1:0]       acc_src, acc_val;
   logic [VALUE_BITS+3:0]       acc_sum;
   logic                        acc_ovf;
   logic [VALUE_BITS+31:0]      first_ext, second_ext;

   assign dg       = spl_pkg::is_digit(rx_byte);
   assign ws       = spl_pkg::is_space(rx_byte);
   assign cm       = (rx_byte == spl_pkg::CHAR_COMMA);
   assign digit    = rx_byte[3:0];
   assign line_end = cr_pending_ff && (rx_byte == spl_pkg::CHAR_LF);

   // pending CR that was not followed by LF acts as whitespace first
   always_comb begin
      ph_mid = phase_ff;
      if (cr_pending_ff) begin
         unique case (phase_ff)
            spl_pkg::PH_SEARCH: ph_mid = spl_pkg::PH_SEARCH;
            spl_pkg::PH_FIRST:  ph_mid = spl_pkg::PH_GAP1;
            spl_pkg::PH_GAP1:   ph_mid = spl_pkg::PH_GAP1;
            spl_pkg::PH_GAP2:   ph_mid = spl_pkg::PH_GAP2;
            default:            ph_mid = spl_pkg::PH_DONE;
         endcase
      end
   end

   // value*10 + digit, saturating at VALUE_BITS
   always_comb begin
      unique case (ph_mid)
         spl_pkg::PH_FIRST:  acc_src = first_ff;
         spl_pkg::PH_SECOND: acc_src = second_ff;
         default:            acc_src = '0;
      endcase
      acc_sum = ({4'b0, acc_src} << 3) + ({4'b0, acc_src} << 1)
              + {{VALUE_BITS{1'b0}}, digit};
      acc_ovf = |acc_sum[VALUE_BITS+3:VALUE_BITS];
      acc_val = acc_ovf ? {VALUE_BITS{1'b1}} : acc_sum[VALUE_BITS-1:0];
   end

   always_comb begin
      phase_in      = phase_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      clamp_in      = clamp_ff;
      cr_pending_in = 1'b0;
      if (line_end) begin
         phase_in  = spl_pkg::PH_SEARCH;
         first_in  = '0;
         second_in = '0;
         clamp_in  = 1'b0;
      end else if (rx_byte == spl_pkg::CHAR_CR) begin
         phase_in      = ph_mid;
         cr_pending_in = 1'b1;
      end else begin
         phase_in = ph_mid;
         unique case (ph_mid)
            spl_pkg::PH_SEARCH: begin
               if (dg) begin
                  phase_in  = spl_pkg::PH_FIRST;
                  first_in  = acc_val;
                  second_in = '0;
                  clamp_in  = 1'b0;
               end
            end
            spl_pkg::PH_FIRST: begin
               priority if (dg) begin
                  first_in = acc_val;
                  clamp_in = clamp_ff | acc_ovf;
               end else if (ws) begin
                  phase_in = spl_pkg::PH_GAP1;
               end else if (cm) begin
                  phase_in = spl_pkg::PH_GAP2;
               end else begin
                  phase_in = spl_pkg::PH_SEARCH;
               end
            end
            spl_pkg::PH_GAP1: begin
               priority if (dg) begin
                  phase_in  = spl_pkg::PH_FIRST;
                  first_in  = acc_val;
                  second_in = '0;
                  clamp_in  = 1'b0;
               end else if (cm) begin
                  phase_in = spl_pkg::PH_GAP2;
               end else if (!ws) begin
                  phase_in = spl_pkg::PH_SEARCH;
               end else begin
                  phase_in = spl_pkg::PH_GAP1;
               end
            end
            spl_pkg::PH_GAP2: begin
               priority if (dg) begin
                  phase_in  = spl_pkg::PH_SECOND;
                  second_in = acc_val;
                  clamp_in  = clamp_ff | acc_ovf;
               end else if (!ws) begin
                  phase_in = spl_pkg::PH_SEARCH;
               end else begin
                  phase_in = spl_pkg::PH_GAP2;
               end
            end
            spl_pkg::PH_SECOND: begin
               if (dg) begin
                  second_in = acc_val;
                  clamp_in  = clamp_ff | acc_ovf;
               end else begin
                  phase_in = spl_pkg::PH_DONE;
               end
            end
            default: phase_in = spl_pkg::PH_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= spl_pkg::PH_SEARCH;
         cr_pending_ff <= 1'b0;
         clamp_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         cr_pending_ff <= cr_pending_in;
         clamp_ff      <= clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign first_ext  = {32'b0, first_ff};
   assign second_ext = {32'b0, second_ff};

   always_comb begin
      scan_res.emit = line_end &&
         ((phase_ff == spl_pkg::PH_SECOND) || (phase_ff == spl_pkg::PH_DONE));
      scan_res.controller_id   = first_ext[spl_pkg::OUT_W-1:0];
      scan_res.bit_mask        = second_ext[spl_pkg::OUT_W-1:0];
      scan_res.value_saturated = clamp_ff;
   end

   a_emit_needs_cr: assert property (@(posedge clock) disable iff (reset)
      scan_res.emit |-> cr_pending_ff)
      else $error("result raised without a pending CR");

   a_cr_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (step && (rx_byte == spl_pkg::CHAR_CR)) |=> cr_pending_ff)
      else $error("CR beat did not leave a pending CR");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && line_end) |=> (phase_ff == spl_pkg::PH_SEARCH) && !cr_pending_ff
                             && !clamp_ff)
      else $error("line end did not clear the scan state");

endmodule

/* rtl/core/spl_rsp.sv */
// ----------------------------------------------------------------------------
// spl_rsp : result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module spl_rsp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  spl_pkg::scan_result_type load_res,
   input  logic                     rsp_stall,
   output logic                     free,
   output logic                     rsp_valid,
   output logic [spl_pkg::OUT_W-1:0] rsp_controller_id,
   output logic [spl_pkg::OUT_W-1:0] rsp_bit_mask,
   output logic                     rsp_value_saturated
);

   logic                      valid_ff, valid_in;
   logic [spl_pkg::OUT_W-1:0] id_ff, mask_ff;
   logic                      sat_ff;

   // free when empty or being drained this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         id_ff   <= load_res.controller_id;
         mask_ff <= load_res.bit_mask;
         sat_ff  <= load_res.value_saturated;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_controller_id   = id_ff;
   assign rsp_bit_mask        = mask_ff;
   assign rsp_value_saturated = sat_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register loaded while a stalled beat is held");

endmodule

/* rtl/core/sensor_pair_line_parser.sv */
// ----------------------------------------------------------------------------
// sensor_pair_line_parser : CR LF line parser for "id , mask" pairs
// Scans a byte stream and reports the first decimal pair of each line that has one.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | req_rx_byte[7:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_controller_id[31:0],
//          |           |                      | rsp_bit_mask[31:0], rsp_value_saturated
//
//  One byte per clock while req_stall is low; the LF beat that ends a line is
//  taken into the input register, and its result then into the result register.
//  The scan update (one x10 + digit add with overflow check) sits between the
//  input register and the state/result registers.
//  Synchronous active-high reset clears scan phase, pending CR and valids.
//  req_stall rises only while a line-ending beat waits on a full, stalled
//  result register; ordinary bytes keep flowing while a result is held.
// ----------------------------------------------------------------------------
module sensor_pair_line_parser #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_controller_id,
   output logic [31:0] rsp_bit_mask,
   output logic        rsp_value_saturated
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_take;

   // scan and result register hookup
   spl_pkg::scan_result_type scan_res;
   logic                     out_free;
   logic                     advance;

   // a beat in the input register moves on unless it produces a result
   // that the result register cannot take this cycle
   assign advance   = in_valid_ff && (!scan_res.emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   spl_scan #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .rx_byte  (in_byte_ff),
      .scan_res (scan_res)
   );

   spl_rsp u_rsp (
      .clock               (clock),
      .reset               (reset),
      .load                (advance && scan_res.emit),
      .load_res            (scan_res),
      .rsp_stall           (rsp_stall),
      .free                (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_controller_id   (rsp_controller_id),
      .rsp_bit_mask        (rsp_bit_mask),
      .rsp_value_saturated (rsp_value_saturated)
   );

   // a held input beat means the result side is full and stalled
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (rsp_valid && rsp_stall && scan_res.emit))
      else $error("input beat held without a blocked result");

   // a held beat is still there next cycle with the same byte
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input beat lost or changed");

endmodule

/* tb/spl_checker.sv */
// ----------------------------------------------------------------------------
// spl_checker : scoreboard for the sensor pair line parser
// Watches both channels. It keeps its own line scanner and queues the pair
// that each CR LF line end should report. Returned beats are compared in
// order against that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spl_checker #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_controller_id,
   input  logic [31:0] rsp_bit_mask,
   input  logic        rsp_value_saturated,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned result_count,
   output int unsigned clamp_count
);

   typedef enum logic [2:0] {
      SCAN_SEARCH,
      SCAN_FIRST,
      SCAN_GAP1,
      SCAN_GAP2,
      SCAN_SECOND,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [31:0] controller_id;
      logic [31:0] bit_mask;
      logic        saturated;
   } sensor_pair_type;

   scan_phase_type             phase    = SCAN_SEARCH;
   logic [VALUE_BITS-1:0]      id_acc   = '0;
   logic [VALUE_BITS-1:0]      mask_acc = '0;
   logic                       cr_held  = 1'b0;
   logic                       clamped  = 1'b0;
   sensor_pair_type            pair_q[$];
   int unsigned                errs      = 0;
   int unsigned                n_pairs   = 0;
   int unsigned                n_clamped = 0;

   // decimal accumulate, clamping to all ones on overflow
   function automatic logic [VALUE_BITS-1:0] times_ten_plus(input logic [VALUE_BITS-1:0] v,
                                                            input logic [7:0] c,
                                                            output logic ovf);
      logic [VALUE_BITS+3:0] t;
      t = {4'd0, v} * 10;
      t = t + (c - spl_pkg::CHAR_ZERO);
      ovf = (t[VALUE_BITS+3:VALUE_BITS] != 0);
      return ovf ? '1 : t[VALUE_BITS-1:0];
   endfunction

   task automatic clear_line();
      phase    = SCAN_SEARCH;
      id_acc   = '0;
      mask_acc = '0;
      clamped  = 1'b0;
   endtask

   task automatic start_candidate(input logic [7:0] c);
      logic ovf;
      id_acc   = times_ten_plus('0, c, ovf);
      mask_acc = '0;
      clamped  = ovf;
      phase    = SCAN_FIRST;
   endtask

   task automatic scan_char(input logic [7:0] c);
      logic dg;
      logic ws;
      logic ovf;
      dg = (c >= spl_pkg::CHAR_ZERO) && (c <= spl_pkg::CHAR_NINE);
      ws = (c == spl_pkg::CHAR_SPACE) ||
           ((c >= spl_pkg::CHAR_TAB) && (c <= spl_pkg::CHAR_CR));
      case (phase)
         SCAN_SEARCH: begin
            if (dg) start_candidate(c);
         end
         SCAN_FIRST: begin
            if (dg) begin
               id_acc = times_ten_plus(id_acc, c, ovf);
               clamped |= ovf;
            end else if (ws) phase = SCAN_GAP1;
            else if (c == spl_pkg::CHAR_COMMA) phase = SCAN_GAP2;
            else phase = SCAN_SEARCH;
         end
         SCAN_GAP1: begin
            if (dg) start_candidate(c);
            else if (c == spl_pkg::CHAR_COMMA) phase = SCAN_GAP2;
            else if (!ws) phase = SCAN_SEARCH;
         end
         SCAN_GAP2: begin
            if (dg) begin
               mask_acc = times_ten_plus('0, c, ovf);
               clamped |= ovf;
               phase = SCAN_SECOND;
            end else if (!ws) phase = SCAN_SEARCH;
         end
         SCAN_SECOND: begin
            if (dg) begin
               mask_acc = times_ten_plus(mask_acc, c, ovf);
               clamped |= ovf;
            end else phase = SCAN_DONE;
         end
         default: phase = SCAN_DONE;
      endcase
   endtask

   // a CR is held back until the next byte shows whether it ends the line
   task automatic take_byte(input logic [7:0] c);
      sensor_pair_type line_pair;
      if (cr_held) begin
         cr_held = 1'b0;
         if (c == spl_pkg::CHAR_LF) begin
            if (phase == SCAN_SECOND || phase == SCAN_DONE) begin
               line_pair = '{32'(id_acc), 32'(mask_acc), clamped};
               pair_q    = {pair_q, line_pair};
            end
            clear_line();
            return;
         end
         scan_char(spl_pkg::CHAR_CR);
      end
      if (c == spl_pkg::CHAR_CR) cr_held = 1'b1;
      else scan_char(c);
   endtask

   task automatic check_pair();
      sensor_pair_type exp;
      if (pair_q.size() == 0) begin
         errs++;
         $display("%0t: unexpected result beat, expected none, got id %0d mask %0d sat %0b",
                  $time, rsp_controller_id, rsp_bit_mask, rsp_value_saturated);
         return;
      end
      exp = pair_q.pop_front();
      n_pairs++;
      if (exp.saturated) n_clamped++;
      if (rsp_controller_id !== exp.controller_id) begin
         errs++;
         $display("%0t: controller_id expected %0d, got %0d",
                  $time, exp.controller_id, rsp_controller_id);
      end
      if (rsp_bit_mask !== exp.bit_mask) begin
         errs++;
         $display("%0t: bit_mask expected %0d, got %0d", $time, exp.bit_mask, rsp_bit_mask);
      end
      if (rsp_value_saturated !== exp.saturated) begin
         errs++;
         $display("%0t: value_saturated expected %0b, got %0b",
                  $time, exp.saturated, rsp_value_saturated);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         cr_held = 1'b0;
         pair_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_pair();
         if (req_valid && !req_stall) take_byte(req_rx_byte);
      end
      fail_count   <= errs;
      pending      <= pair_q.size();
      result_count <= n_pairs;
      clamp_count  <= n_clamped;
   end

endmodule

/* tb/tb_sensor_pair_line_parser.sv */
// ----------------------------------------------------------------------------
// tb_sensor_pair_line_parser : top of the line parser testbench
// Feeds text lines to the parser in bursts, stalls the result side on a
// pattern of its own and leaves the checking to spl_checker. It starts with
// short hand-written lines for the corner cases. Then come random lines,
// mostly well-formed "id , mask" lines with random content.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_pair_line_parser;

   localparam int unsigned ITEM_TARGET   = 1450;  // random beats, on top of ~100 directed
   localparam int unsigned DRAIN_LIMIT   = 5000;  // cycles to wait for late results
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam logic [7:0]  CHAR_VT       = 8'h0B;
   localparam logic [7:0]  CHAR_FF       = 8'h0C;

   // every input is known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [31:0] rsp_controller_id;
   logic [31:0] rsp_bit_mask;
   logic        rsp_value_saturated;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned result_count;
   int unsigned clamp_count;

   logic [7:0]  line_q[$];       // bytes of the line being built
   int unsigned beats_sent = 0;
   int unsigned lines_sent = 0;
   int unsigned burst_left = 0;
   int unsigned rsp_run    = 0;

   always #5 clock = ~clock;

   sensor_pair_line_parser i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_controller_id   (rsp_controller_id),
      .rsp_bit_mask        (rsp_bit_mask),
      .rsp_value_saturated (rsp_value_saturated)
   );

   spl_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_controller_id   (rsp_controller_id),
      .rsp_bit_mask        (rsp_bit_mask),
      .rsp_value_saturated (rsp_value_saturated),
      .fail_count          (fail_count),
      .pending             (pending),
      .result_count        (result_count),
      .clamp_count         (clamp_count)
   );

   // Result side: stalled or free runs of random length, picked at random. Free
   // runs have a wider range, so there are stretches with no back-pressure. Only
   // a line end is held up by a stalled result; other bytes keep flowing.
   always @(negedge clock) begin
      if (rsp_run == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            rsp_run   <= $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b0;
            rsp_run   <= $urandom_range(1, 30);
         end
      end else begin
         rsp_run <= rsp_run - 1;
      end
   end

   // One beat on the request side. Bursts of random length, now and then a
   // long one, with random gaps between them. A gap can land anywhere in a
   // line. Valid drops only at the start of a gap and never in the same step
   // where it rises again.
   task automatic put_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      // req_stall seen here is its value at this edge, before the update
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // append one byte to the line being built
   task automatic add_byte(input logic [7:0] b);
      line_q = {line_q, b};
   endtask

   // close the line with CR LF and send it out
   task automatic end_line();
      add_byte(spl_pkg::CHAR_CR);
      add_byte(spl_pkg::CHAR_LF);
      foreach (line_q[i]) put_byte(line_q[i]);
      line_q.delete();
      lines_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Mostly nothing. Otherwise one to three of space, tab, LF, VT, FF or CR.
   task automatic push_blanks();
      int unsigned n;
      int unsigned r;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) begin
         r = $urandom_range(0, 5);
         add_byte((r == 5) ? spl_pkg::CHAR_SPACE : spl_pkg::CHAR_TAB + 8'(r));
      end
   endtask

   // Decimal number. Small values, full 32-bit values and the all-ones edge.
   // Also values just past it, 64-bit values that saturate, zero and leading
   // zeros.
   task automatic push_number();
      logic [63:0] v;
      logic [7:0]  digs[$];
      int unsigned zeros;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, 999);
         4, 5:       v = $urandom();
         6:          v = 64'hFFFF_FFFF;
         7:          v = 64'h1_0000_0000 + $urandom_range(0, 9);
         8:          v = {$urandom(), $urandom()};
         default:    v = 64'd0;
      endcase
      zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      repeat (zeros) add_byte(spl_pkg::CHAR_ZERO);
      do begin
         digs.push_front(spl_pkg::CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i]) add_byte(digs[i]);
   endtask

   // Most lines carry a well-formed pair with optional junk around it. Others
   // are broken pairs, raw noise over the full byte range, or blank lines.
   task automatic random_line();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(8'h3A, 8'h7E)));
            push_number();
            push_blanks();
            add_byte(spl_pkg::CHAR_COMMA);
            push_blanks();
            push_number();
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
         end
         7: begin
            push_number();
            push_blanks();
            case ($urandom_range(0, 2))
               0: begin
                  add_byte(8'($urandom_range(8'h3A, 8'h7E)));
                  push_number();
               end
               1: begin
                  add_byte(spl_pkg::CHAR_COMMA);
                  push_blanks();
                  add_byte(8'($urandom_range(8'h3A, 8'h7E)));
               end
               default: begin
                  add_byte(spl_pkg::CHAR_COMMA);
                  push_blanks();
               end
            endcase
            if ($urandom_range(0, 1) == 0) begin
               add_byte(spl_pkg::CHAR_COMMA);
               push_number();
            end
         end
         8: repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
         default: push_blanks();
      endcase
      end_line();
   endtask

   initial begin
      int unsigned random_start;
      int unsigned waited;
      int unsigned leftover;
      int unsigned failures;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed lines ---
      push_text("12,34");                        // plain pair
      end_line();
      end_line();                                // empty line: no result
      push_text("4294967295 ,");                 // largest 32-bit value, blank before comma
      add_byte(spl_pkg::CHAR_TAB);
      push_text("0");
      end_line();
      push_text("7");                            // VT and FF as blanks
      add_byte(CHAR_VT);
      push_text(",");
      add_byte(CHAR_FF);
      push_text("8");
      end_line();
      push_text("4294967296,99999999999");       // both numbers clamp
      end_line();
      push_text("1 2");                          // failed candidate restarts at the 2,
      add_byte(spl_pkg::CHAR_CR);                // and a lone CR counts as a blank
      push_text(",3");
      end_line();
      push_text("12a34,5 6,7");                  // letter breaks the run; first match wins
      end_line();
      push_text("x");                            // LF without CR is only a blank
      add_byte(spl_pkg::CHAR_LF);
      push_text("9,");
      add_byte(spl_pkg::CHAR_LF);
      push_text("0");
      end_line();
      push_text("1,2");                          // CR CR LF: first CR is a blank
      add_byte(spl_pkg::CHAR_CR);
      end_line();
      add_byte(8'h00);                           // all bits low and high, no match
      add_byte(8'hFF);
      push_text(",5");
      end_line();
      push_text("abc");
      end_line();

      // --- random lines ---
      random_start = beats_sent;
      while (beats_sent - random_start < ITEM_TARGET) random_line();
      req_valid <= 1'b0;

      // let outstanding results drain, then watch a little longer for strays
      waited = 0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      leftover = pending;
      if (leftover != 0)
         $display("%0t: %0d expected results never arrived", $time, leftover);
      failures = fail_count + leftover;

      $display("Sent %0d beats in %0d lines; %0d pairs checked, %0d of them saturated.",
               beats_sent, lines_sent, result_count, clamp_count);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* sensor_pair_line_parser.f */
rtl/core/spl_pkg.sv
rtl/core/spl_scan.sv
rtl/core/spl_rsp.sv
rtl/core/sensor_pair_line_parser.sv
tb/spl_checker.sv
tb/tb_sensor_pair_line_parser.sv
